// ----- src/elevator_request_controller_top_macros.svh -----
// ----------------------------------------------------------------------------
// elevator request controller assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_REQUEST_CONTROLLER_TOP_MACROS_SVH
`define ELEVATOR_REQUEST_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define ELC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/elc_pkg.sv -----
// ----------------------------------------------------------------------------
// elevator request controller package
// payload, state types and fixed constants
// ----------------------------------------------------------------------------
package elc_pkg;

    localparam int FLOOR_COUNT = 4;
    localparam int FLOOR_W     = $clog2(FLOOR_COUNT);
    localparam int TICKS_W     = 16;

    localparam logic [TICKS_W-1:0] DOOR_TICKS_RESET = TICKS_W'(300);

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_UP   = 2'd1;
    localparam logic [1:0] MOTOR_DOWN = 2'd2;

    typedef logic [FLOOR_COUNT-1:0] floor_mask_t;
    typedef logic [FLOOR_W-1:0]     floor_t;

    typedef struct packed {
        logic        sensor_valid;
        floor_t      sensor_floor;
        floor_mask_t hall_up_buttons;
        floor_mask_t hall_down_buttons;
        floor_mask_t cab_buttons;
        logic        stop_pressed;
        logic        obstructed;
    } elc_sample_t;

    typedef struct packed {
        logic [1:0]  motor_cmd;
        logic        door_lamp;
        logic        stop_lamp;
        floor_t      floor_indicator;
        floor_mask_t up_lamps;
        floor_mask_t down_lamps;
        floor_mask_t cab_lamps;
    } elc_result_t;

    typedef struct packed {
        floor_mask_t        up_requests;
        floor_mask_t        down_requests;
        floor_mask_t        cab_requests;
        floor_t             current_floor;
        logic               moving_up;
        logic               halted;
        logic               door_open;
        logic [TICKS_W-1:0] door_countdown;
        logic               homing;
    } elc_state_t;

    localparam elc_state_t ELC_STATE_RESET = '{
        up_requests:    '0,
        down_requests:  '0,
        cab_requests:   '0,
        current_floor:  '0,
        moving_up:      1'b1,
        halted:         1'b1,
        door_open:      1'b0,
        door_countdown: '0,
        homing:         1'b1
    };

endpackage

// ----- src/elc_chan_if.sv -----
// ----------------------------------------------------------------------------
// elevator request controller channel
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface elc_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ----- src/elevator_request_controller_top.sv -----
// ----------------------------------------------------------------------------
// elevator request controller
// four-floor request latching, arrival rule, door timer and direction
// choice, one sample in and one result out per transfer
// ----------------------------------------------------------------------------
//  channel  role    payload
//  sample   sink    sensor, hall and cab buttons, stop, obstruction
//  result   source  motor, lamps, floor indicator
//  cfg      sink    door_open_ticks, always ready
//
//  one sample per cycle sustained while result is ready; result passes the sample register, then the result register
//  sample register feeds the tick logic, which loads the result register
//  and the controller state in the same cycle
//  rst_n clears state to homing (drive down until floor 0), door ticks to 300
//  a stalled result holds the pipe; a sample still lands only in an empty input register
// ----------------------------------------------------------------------------
`include "elevator_request_controller_top_macros.svh"

module elevator_request_controller_top (
    input  logic       clk,
    input  logic       rst_n,
    elc_chan_if.sink   sample,
    elc_chan_if.source result,
    elc_chan_if.sink   cfg
);
    import elc_pkg::*;

    logic               in_valid_reg;
    elc_sample_t        in_reg;
    logic               out_valid_reg;
    elc_result_t        out_reg;
    elc_state_t         state_reg;
    elc_state_t         state_next;
    elc_result_t        out_next;
    logic [TICKS_W-1:0] door_ticks_reg;
    logic               advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    elc_step u_step (
        .state_cur       (state_reg),
        .sample          (in_reg),
        .door_open_ticks (door_ticks_reg),
        .state_nxt       (state_next),
        .result          (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ELC_STATE_RESET;
            door_ticks_reg <= DOOR_TICKS_RESET;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                door_ticks_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_reg <= sample.data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    `ELC_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "result register not loaded")
    `ELC_ASSERT_NOW(a_door_motor_stop, out_valid_reg && out_reg.door_lamp, out_reg.motor_cmd == MOTOR_STOP, "motor driven with door open")
    `ELC_ASSERT_NOW(a_stop_clears, out_valid_reg && out_reg.stop_lamp, (out_reg.motor_cmd == MOTOR_STOP) && (out_reg.up_lamps == '0) && (out_reg.down_lamps == '0) && (out_reg.cab_lamps == '0), "stop left requests or motion")
    `ELC_ASSERT_NOW(a_homing_empty, state_reg.homing, (state_reg.up_requests == '0) && (state_reg.down_requests == '0) && (state_reg.cab_requests == '0) && !state_reg.door_open, "requests or door while homing")

endmodule

// ----- src/elc_step.sv -----
// ----------------------------------------------------------------------------
// elevator request controller tick logic
// next state and result for one sample: homing, stop, door timer,
// arrival rule and direction scans
// ----------------------------------------------------------------------------
module elc_step (
    input  elc_pkg::elc_state_t               state_cur,
    input  elc_pkg::elc_sample_t              sample,
    input  logic [elc_pkg::TICKS_W-1:0]       door_open_ticks,
    output elc_pkg::elc_state_t               state_nxt,
    output elc_pkg::elc_result_t              result
);
    import elc_pkg::*;

    always_comb
    begin
        elc_state_t  s;
        logic        at_floor;
        logic        stop_lamp;
        logic [1:0]  motor;
        floor_mask_t above_m;
        floor_mask_t below_m;
        floor_mask_t bit_m;
        floor_mask_t seen;
        floor_mask_t any_req;
        logic        req_above;
        logic        req_below;

        s         = state_cur;
        stop_lamp = 1'b0;
        at_floor  = sample.sensor_valid && (int'(sample.sensor_floor) < FLOOR_COUNT);
        above_m   = '0;
        below_m   = '0;
        bit_m     = '0;
        seen      = '0;
        any_req   = '0;
        req_above = 1'b0;
        req_below = 1'b0;

        if (s.homing)
        begin
            if (sample.sensor_valid && (sample.sensor_floor == '0))
            begin
                s = ELC_STATE_RESET;
                s.homing = 1'b0;
            end
            motor = s.homing ? MOTOR_DOWN : MOTOR_STOP;
        end
        else
        begin
            s.up_requests   = s.up_requests   | sample.hall_up_buttons;
            s.down_requests = s.down_requests | sample.hall_down_buttons;
            s.cab_requests  = s.cab_requests  | sample.cab_buttons;
            if (at_floor)
            begin
                s.current_floor = sample.sensor_floor;
            end

            for (int i = 0; i < FLOOR_COUNT; i++)
            begin
                above_m[i] = (i > int'(s.current_floor));
                below_m[i] = (i < int'(s.current_floor));
                bit_m[i]   = (i == int'(s.current_floor));
            end

            if (sample.stop_pressed)
            begin
                stop_lamp       = 1'b1;
                s.up_requests   = '0;
                s.down_requests = '0;
                s.cab_requests  = '0;
                s.halted        = 1'b1;
                if (at_floor)
                begin
                    s.door_open      = 1'b1;
                    s.door_countdown = door_open_ticks;
                end
            end
            else if (s.door_open)
            begin
                if (sample.obstructed)
                begin
                    s.door_countdown = door_open_ticks;
                end
                else if (s.door_countdown <= TICKS_W'(1))
                begin
                    s.door_open      = 1'b0;
                    s.door_countdown = '0;
                end
                else
                begin
                    s.door_countdown = s.door_countdown - TICKS_W'(1);
                end
            end
            else
            begin
                // arrival rule
                if (at_floor)
                begin
                    if ((s.down_requests & bit_m) != '0)
                    begin
                        seen = s.up_requests | s.cab_requests
                             | (s.moving_up ? s.down_requests : '0);
                        if ((seen & above_m) == '0)
                        begin
                            s.door_open     = 1'b1;
                            s.halted        = 1'b1;
                            s.down_requests = s.down_requests & ~bit_m;
                        end
                    end
                    if ((s.up_requests & bit_m) != '0)
                    begin
                        seen = s.up_requests | s.cab_requests
                             | (s.moving_up ? '0 : s.down_requests);
                        if ((seen & below_m) == '0)
                        begin
                            s.door_open   = 1'b1;
                            s.halted      = 1'b1;
                            s.up_requests = s.up_requests & ~bit_m;
                        end
                    end
                    if ((s.cab_requests & bit_m) != '0)
                    begin
                        s.door_open    = 1'b1;
                        s.halted       = 1'b1;
                        s.cab_requests = s.cab_requests & ~bit_m;
                    end
                end

                if (s.door_open)
                begin
                    s.door_countdown = door_open_ticks;
                end
                else
                begin
                    // direction scans
                    any_req   = s.up_requests | s.down_requests | s.cab_requests;
                    req_above = (any_req & above_m) != '0;
                    req_below = (any_req & below_m) != '0;
                    if (s.current_floor == FLOOR_W'(FLOOR_COUNT - 1))
                    begin
                        s.moving_up = 1'b0;
                        if (req_below)
                        begin
                            s.halted = 1'b0;
                        end
                    end
                    else if (s.current_floor == '0)
                    begin
                        s.moving_up = 1'b1;
                        if (req_above)
                        begin
                            s.halted = 1'b0;
                        end
                    end
                    else if (s.moving_up)
                    begin
                        if (req_above)
                        begin
                            s.halted = 1'b0;
                        end
                        else if (req_below)
                        begin
                            s.moving_up = 1'b0;
                            s.halted    = 1'b0;
                        end
                    end
                    else
                    begin
                        if (req_below)
                        begin
                            s.halted = 1'b0;
                        end
                        else if (req_above)
                        begin
                            s.moving_up = 1'b1;
                            s.halted    = 1'b0;
                        end
                    end
                end
            end
            motor = s.halted ? MOTOR_STOP : (s.moving_up ? MOTOR_UP : MOTOR_DOWN);
        end

        state_nxt              = s;
        result.motor_cmd       = motor;
        result.door_lamp       = s.door_open;
        result.stop_lamp       = stop_lamp;
        result.floor_indicator = s.current_floor;
        result.up_lamps        = s.up_requests;
        result.down_lamps      = s.down_requests;
        result.cab_lamps       = s.cab_requests;
    end

endmodule
